FILE: design/opcw_pkg.sv
// Shared types and constants for the object pass counter.
package opcw_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TIME_W     = 32;
  localparam int DEAD_W     = 16;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_WIN  = CFG_IDX_W'(1);

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = SAMPLE_W'(512);
  localparam logic [DEAD_W-1:0]   DEAD_WIN_RST  = DEAD_W'(500);
  localparam logic [COUNT_W-1:0]  COUNT_MAX     = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_SRCH,
    ST_FIN
  } opcw_state_t;

  // Per-cycle commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;     // new beat accepted: write window, clear accumulators
    logic rd_en;    // issue a window read
    logic acc;      // add returned read data into the sum
    logic div_step; // take the mean by reciprocal multiplication
    logic cmp;      // distance compare on returned read data
    logic commit;   // update count state and load the result register
  } opcw_ctrl_t;

endpackage

FILE: design/opcw_if.sv
// Valid/ready channel interfaces for samples, results and configuration.
interface opcw_in_if;
  import opcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] ir_sample;
  logic [TIME_W-1:0]   now_ms;
  modport source (output valid, output ir_sample, output now_ms, input ready);
  modport sink   (input valid, input ir_sample, input now_ms, output ready);
endinterface

interface opcw_out_if;
  import opcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [COUNT_W-1:0]  object_count;
  logic                object_present;
  logic                counted_now;
  logic [SAMPLE_W-1:0] filtered_level;
  modport source (output valid, output object_count, output object_present,
                  output counted_now, output filtered_level, input ready);
  modport sink   (input valid, input object_count, input object_present,
                  input counted_now, input filtered_level, output ready);
endinterface

interface opcw_cfg_if;
  import opcw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/opcw_seq.sv
// Sequencer that steps the shared datapath through sum, divide and search.
module opcw_seq #(
  parameter int WINDOW_LEN = 8,
  localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_free,
  output logic                  in_ready,
  output opcw_pkg::opcw_ctrl_t  ctrl,
  output logic [AW-1:0]         rd_addr
);
  import opcw_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam logic [CNT_W-1:0] LAST_RD = CNT_W'(WINDOW_LEN);

  opcw_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SUM;
      ST_SUM:  if (cnt_r == LAST_RD) state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_SRCH;
      ST_SRCH: if (cnt_r == LAST_RD) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (state_r != state_nxt) begin
      cnt_nxt = '0;
    end else if (state_r == ST_IDLE || state_r == ST_FIN) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      ST_SUM: begin
        ctrl.rd_en = (cnt_r < LAST_RD);
        ctrl.acc   = (cnt_r != '0);
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
      end
      ST_SRCH: begin
        ctrl.rd_en = (cnt_r < LAST_RD);
        ctrl.cmp   = (cnt_r != '0);
      end
      ST_FIN: begin
        ctrl.commit = out_free;
      end
      default: ctrl = '0;
    endcase
  end

  assign rd_addr = cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: design/opcw_dpath.sv
// Window memory, shared add/subtract unit and object counting state.
module opcw_dpath #(
  parameter int WINDOW_LEN = 8,
  localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  opcw_pkg::opcw_ctrl_t           ctrl,
  input  logic [AW-1:0]                  rd_addr,
  input  logic [opcw_pkg::SAMPLE_W-1:0]  ir_sample,
  input  logic [opcw_pkg::TIME_W-1:0]    now_ms,
  input  logic [opcw_pkg::SAMPLE_W-1:0]  threshold,
  input  logic [opcw_pkg::DEAD_W-1:0]    dead_win,
  output logic [opcw_pkg::COUNT_W-1:0]   res_count,
  output logic                           res_present,
  output logic                           res_counted,
  output logic [opcw_pkg::SAMPLE_W-1:0]  res_level
);
  import opcw_pkg::*;

  localparam int LW    = $clog2(WINDOW_LEN);
  localparam int SUM_W = SAMPLE_W + LW;
  localparam int UW    = SUM_W + 1;
  localparam int RCW   = SUM_W + 2;
  localparam int PW    = SUM_W + RCW;
  localparam int SHIFT = SUM_W + LW;
  localparam logic [AW-1:0]  LAST_SLOT = AW'(WINDOW_LEN - 1);
  // Rounded-up reciprocal of the window length, scaled by 2^SHIFT.
  localparam logic [RCW-1:0] RECIP     =
    RCW'(((1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

  logic [SAMPLE_W-1:0]   win_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] valid_r;
  logic [AW-1:0]         wslot_r;
  logic [SAMPLE_W-1:0]   rd_data_r;
  logic                  rd_vb_r;
  logic [SAMPLE_W-1:0]   rd_val;

  logic [SUM_W-1:0]      sum_r;
  logic [SAMPLE_W-1:0]   quo_r;
  logic [SAMPLE_W:0]     best_dist_r;
  logic [SAMPLE_W-1:0]   best_val_r;
  logic [TIME_W-1:0]     now_r;

  logic [TIME_W-1:0]     last_r;
  logic                  present_r;
  logic [COUNT_W-1:0]    count_r;

  logic [UW-1:0]         op_a, op_b, alu_res, neg_res;
  logic                  op_sub, alu_neg;
  logic [PW-1:0]         mean_prod;
  logic [SAMPLE_W-1:0]   delta;
  logic [TIME_W-1:0]     elapsed;
  logic                  above, counted;

  // Window storage with a registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      win_mem[wslot_r] <= ir_sample;
    end
    if (ctrl.rd_en) begin
      rd_data_r <= win_mem[rd_addr];
    end
  end

  // Entries never written read as zero.
  assign rd_val = rd_vb_r ? rd_data_r : '0;

  // The truncated mean is the sum times the scaled reciprocal; the rounding
  // error stays below one part in WINDOW_LEN, so the floor is exact.
  assign mean_prod = PW'(sum_r) * PW'(RECIP);

  // One adder serves accumulation and the distances.
  always_comb begin
    op_a   = UW'(sum_r);
    op_b   = UW'(rd_val);
    op_sub = 1'b0;
    if (ctrl.cmp) begin
      op_a   = UW'(rd_val);
      op_b   = UW'(quo_r);
      op_sub = 1'b1;
    end
  end

  assign alu_res = op_a + (op_sub ? ~op_b : op_b) + UW'(op_sub);
  assign alu_neg = alu_res[UW-1];
  assign neg_res = ~alu_res + 1'b1;
  assign delta   = alu_neg ? neg_res[SAMPLE_W-1:0] : alu_res[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sum_r       <= '0;
      best_dist_r <= '1;
      now_r       <= now_ms;
    end else if (ctrl.acc) begin
      sum_r <= alu_res[SUM_W-1:0];
    end else if (ctrl.div_step) begin
      quo_r <= mean_prod[SHIFT +: SAMPLE_W];
    end else if (ctrl.cmp) begin
      if ({1'b0, delta} < best_dist_r) begin
        best_dist_r <= {1'b0, delta};
        best_val_r  <= rd_val;
      end
    end
  end

  // Detection decision on the filtered level.
  assign elapsed     = now_r - last_r;
  assign above       = (best_val_r > threshold);
  assign counted     = above && (elapsed > TIME_W'(dead_win)) && !present_r;
  assign res_count   = (counted && (count_r != COUNT_MAX)) ? count_r + 1'b1 : count_r;
  assign res_present = above && (present_r || counted);
  assign res_counted = counted;
  assign res_level   = best_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      wslot_r   <= '0;
      rd_vb_r   <= 1'b0;
      last_r    <= '0;
      present_r <= 1'b1;
      count_r   <= '0;
    end else begin
      if (ctrl.load) begin
        valid_r[wslot_r] <= 1'b1;
        wslot_r          <= (wslot_r == LAST_SLOT) ? '0 : wslot_r + 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_vb_r <= valid_r[rd_addr];
      end
      if (ctrl.commit) begin
        count_r   <= res_count;
        present_r <= res_present;
        if (counted) begin
          last_r <= now_r;
        end
      end
    end
  end

endmodule

FILE: design/object_pass_counter_window_filter.sv
// Object pass counter: each sample beat enters an eight-deep (WINDOW_LEN) ring
// window, the block finds the stored sample nearest the truncated window mean
// and counts an object when that level rises above detect_threshold, no object
// is flagged present and more than dead_window_ms have passed since the last
// count (timestamps wrap modulo 2^32, the count saturates at 65535). The sums
// and distances run through one shared adder under a small sequencer, so a
// beat passes through an accept step, a summing pass over the window (one
// read of the window memory port per cycle), a step that takes the truncated
// mean by multiplying the sum with a constant reciprocal of WINDOW_LEN, a
// nearest-to-mean search pass and a commit cycle. in_ch.ready is high only
// between beats. The result beat sits in an output register; the next sample
// may be accepted while it waits, and a later result holds in the commit cycle
// until that register frees. Configuration writes are always taken
// (cfg_ch.ready is tied high); index 0 sets detect_threshold, index 1 sets
// dead_window_ms, and any other index is ignored. Write configuration only
// while no sample is being processed.
module object_pass_counter_window_filter #(
  parameter int WINDOW_LEN = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  opcw_in_if.sink           in_ch,
  opcw_out_if.source        out_ch,
  opcw_cfg_if.sink          cfg_ch
);
  import opcw_pkg::*;

  localparam int AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  opcw_ctrl_t          ctrl;
  logic [AW-1:0]       rd_addr;
  logic                out_free;

  logic [SAMPLE_W-1:0] threshold_r;
  logic [DEAD_W-1:0]   dead_win_r;

  logic [COUNT_W-1:0]  res_count;
  logic                res_present;
  logic                res_counted;
  logic [SAMPLE_W-1:0] res_level;

  logic                out_valid_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_present_r;
  logic                out_counted_r;
  logic [SAMPLE_W-1:0] out_level_r;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_ch.ready;

  opcw_seq #(.WINDOW_LEN(WINDOW_LEN)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .in_ready (in_ch.ready),
    .ctrl     (ctrl),
    .rd_addr  (rd_addr)
  );

  opcw_dpath #(.WINDOW_LEN(WINDOW_LEN)) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .rd_addr     (rd_addr),
    .ir_sample   (in_ch.ir_sample),
    .now_ms      (in_ch.now_ms),
    .threshold   (threshold_r),
    .dead_win    (dead_win_r),
    .res_count   (res_count),
    .res_present (res_present),
    .res_counted (res_counted),
    .res_level   (res_level)
  );

  // Configuration registers; unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      dead_win_r  <= DEAD_WIN_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_THRESHOLD: threshold_r <= cfg_ch.data[SAMPLE_W-1:0];
        REG_DEAD_WIN:  dead_win_r  <= cfg_ch.data[DEAD_W-1:0];
        default:       ;
      endcase
    end
  end

  // Result register: loaded in the commit cycle, held until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_count_r   <= res_count;
      out_present_r <= res_present;
      out_counted_r <= res_counted;
      out_level_r   <= res_level;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.object_count   = out_count_r;
  assign out_ch.object_present = out_present_r;
  assign out_ch.counted_now    = out_counted_r;
  assign out_ch.filtered_level = out_level_r;

endmodule

FILE: design/opcw_checker.sv
// Port-level assertions for the object pass counter, bound to the top level.
module opcw_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [opcw_pkg::COUNT_W-1:0]   object_count,
  input logic                           object_present,
  input logic                           counted_now
);
  import opcw_pkg::*;

  // A held result beat keeps its count.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(object_count))
    else $error("result beat dropped or changed while stalled");

  // An accepted sample beat leaves the block busy, with in_ready low.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while previous one still in work");

  // A counting beat always leaves the object flagged and a nonzero count.
  a_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && counted_now |-> object_present && (object_count != '0))
    else $error("counted beat without present flag or with zero count");

  // Just after reset no result can be pending.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind object_pass_counter_window_filter opcw_checker u_opcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .object_count   (out_ch.object_count),
  .object_present (out_ch.object_present),
  .counted_now    (out_ch.counted_now)
);
